FILE: design/bsim_pkg.sv
// Shared types and constants for the bank switch scanline IRQ mapper.
// No dependencies; imported by every module of the block.
package bsim_pkg;

	localparam int BSIM_QDEPTH = 2;

	localparam int DATA_W = 8;
	localparam int ADDR_W = 16;
	localparam int CHR_CNT_W = 11;
	localparam int PRG_CNT_W = 9;
	localparam int KIND_W = 3;
	localparam int SLOT_W = 3;
	localparam int CSEL_W = 4;
	localparam int IRQ_CNT_W = 16;

	localparam logic [ADDR_W-1:0] ADDR_SELECT  = 16'h8000;
	localparam logic [ADDR_W-1:0] ADDR_EXECUTE = 16'hA000;
	localparam logic [IRQ_CNT_W-1:0] TICK_DEC  = 16'd113;

	// Configuration register indexes on the write port.
	localparam logic REG_CHR_COUNT = 1'b0;
	localparam logic REG_PRG_COUNT = 1'b1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [CSEL_W-1:0] CSEL_CHR7   = 4'd7;
	localparam logic [CSEL_W-1:0] CSEL_PRG0   = 4'd9;
	localparam logic [CSEL_W-1:0] CSEL_PRG2   = 4'd11;
	localparam logic [CSEL_W-1:0] CSEL_MIRROR = 4'd12;
	localparam logic [CSEL_W-1:0] CSEL_IRQEN  = 4'd13;
	localparam logic [CSEL_W-1:0] CSEL_CNT_LO = 4'd14;
	localparam logic [CSEL_W-1:0] CSEL_CNT_HI = 4'd15;

	localparam logic [KIND_W-1:0] EV_NONE   = 3'd0;
	localparam logic [KIND_W-1:0] EV_CHR    = 3'd1;
	localparam logic [KIND_W-1:0] EV_PRG    = 3'd2;
	localparam logic [KIND_W-1:0] EV_MIRROR = 3'd3;
	localparam logic [KIND_W-1:0] EV_IRQ    = 3'd4;

	// One classified transaction waiting for the back end.
	// When is_mod is set, value holds the dividend and the result is value modulo
	// the bank count that kind selects.
	typedef struct packed {
		logic                is_mod;
		logic [KIND_W-1:0]   kind;
		logic [SLOT_W-1:0]   slot;
		logic [DATA_W-1:0]   value;
	} bsim_entry_t;

endpackage

FILE: design/bsim_front.sv
// Front end: accepts input transactions, keeps command/IRQ state, classifies work.
// Depends on bsim_pkg.
module bsim_front import bsim_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [ADDR_W-1:0]     bus_addr,
	input  logic [DATA_W-1:0]     bus_data,
	input  logic [CHR_CNT_W-1:0]  chr_bank_count,
	input  logic [PRG_CNT_W-1:0]  prg_bank_count,
	input  logic                  q_full,
	output logic                  q_push,
	output bsim_entry_t           q_entry
);

	logic [CSEL_W-1:0]    csel_q;
	logic                 irq_en_q;
	logic [IRQ_CNT_W-1:0] irq_cnt_q;
	logic                 accept;
	logic [CSEL_W-1:0]    csel_sub;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;
	assign csel_sub = csel_q - CSEL_PRG0;

	always_comb begin
		q_entry = '0;
		q_entry.kind = EV_NONE;
		if (cmd == CMD_TICK) begin
			if (irq_en_q && (irq_cnt_q <= TICK_DEC)) begin
				q_entry.kind = EV_IRQ;
			end
		end else if (bus_addr == ADDR_EXECUTE) begin
			if (csel_q <= CSEL_CHR7) begin
				if (chr_bank_count != '0) begin
					q_entry.is_mod = 1'b1;
					q_entry.kind   = EV_CHR;
					q_entry.slot   = csel_q[SLOT_W-1:0];
					q_entry.value  = bus_data;
				end
			end else if (csel_q inside {[CSEL_PRG0:CSEL_PRG2]}) begin
				if (prg_bank_count != '0) begin
					q_entry.is_mod = 1'b1;
					q_entry.kind   = EV_PRG;
					q_entry.slot   = csel_sub[SLOT_W-1:0];
					q_entry.value  = bus_data;
				end
			end else if (csel_q == CSEL_MIRROR) begin
				q_entry.kind  = EV_MIRROR;
				q_entry.value = {{(DATA_W-2){1'b0}}, bus_data[1], ~bus_data[0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csel_q    <= '0;
			irq_en_q  <= 1'b0;
			irq_cnt_q <= '0;
		end else if (accept) begin
			if (cmd == CMD_TICK) begin
				if (irq_en_q) begin
					if (irq_cnt_q <= TICK_DEC) begin
						irq_cnt_q <= '0;
					end else begin
						irq_cnt_q <= irq_cnt_q - TICK_DEC;
					end
				end
			end else if (bus_addr == ADDR_SELECT) begin
				csel_q <= bus_data[CSEL_W-1:0];
			end else if (bus_addr == ADDR_EXECUTE) begin
				case (csel_q)
					CSEL_IRQEN:  irq_en_q <= (bus_data != '0);
					CSEL_CNT_LO: irq_cnt_q[DATA_W-1:0] <= bus_data;
					CSEL_CNT_HI: irq_cnt_q[IRQ_CNT_W-1:DATA_W] <= bus_data;
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: design/bsim_queue.sv
// Small register queue between the front end and the back end.
// Depends on bsim_pkg.
module bsim_queue import bsim_pkg::*; #(
	parameter int QDEPTH = BSIM_QDEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bsim_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        head_valid,
	output bsim_entry_t head
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

	bsim_entry_t       mem_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_FULL)
		else $error("queue occupancy exceeds its depth");
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("pop from an empty queue");

endmodule

FILE: design/bsim_back.sv
// Back end: bit-serial modulo unit and the output register.
// Depends on bsim_pkg.
module bsim_back import bsim_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CHR_CNT_W-1:0]  chr_bank_count,
	input  logic [PRG_CNT_W-1:0]  prg_bank_count,
	input  logic                  head_valid,
	input  bsim_entry_t           head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [KIND_W-1:0]     event_kind,
	output logic [SLOT_W-1:0]     slot,
	output logic [DATA_W-1:0]     bank_value
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam int STEP_W = $clog2(DATA_W + 1);

	logic [1:0]           state_q;
	logic [STEP_W-1:0]    step_q;
	logic [CHR_CNT_W-1:0] div_q;
	logic [CHR_CNT_W-1:0] rem_q;
	logic [DATA_W-1:0]    dvd_q;
	logic [KIND_W-1:0]    kind_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 out_valid_q;
	logic [KIND_W-1:0]    event_kind_q;
	logic [SLOT_W-1:0]    slot_out_q;
	logic [DATA_W-1:0]    bank_value_q;
	logic                 out_free;
	logic                 out_load;
	logic [CHR_CNT_W-1:0] trial;
	logic [CHR_CNT_W-1:0] rem_nxt;

	assign out_free = !out_valid_q || !out_stall;
	assign pop = (state_q == ST_IDLE) && head_valid && (head.is_mod || out_free);
	// The output register takes a new result from a plain entry or from a finished modulo.
	assign out_load = (pop && !head.is_mod) || ((state_q == ST_DONE) && out_free);

	// One quotient bit per cycle: remainder stays below 256, so the shift never overflows.
	assign trial   = {rem_q[CHR_CNT_W-2:0], dvd_q[DATA_W-1]};
	assign rem_nxt = (trial >= div_q) ? trial - div_q : trial;

	always_ff @(posedge clk) begin
		if (pop && head.is_mod) begin
			div_q  <= (head.kind == EV_CHR) ? chr_bank_count
				: {{(CHR_CNT_W-PRG_CNT_W){1'b0}}, prg_bank_count};
			dvd_q  <= head.value;
			rem_q  <= '0;
			kind_q <= head.kind;
			slot_q <= head.slot;
		end else if (state_q == ST_BUSY) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
			event_kind_q <= EV_NONE;
			slot_out_q   <= '0;
			bank_value_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.is_mod) begin
							state_q <= ST_BUSY;
							step_q  <= STEP_W'(DATA_W);
						end else begin
							event_kind_q <= head.kind;
							slot_out_q   <= head.slot;
							bank_value_q <= head.value;
						end
					end
				end
				ST_BUSY: begin
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						event_kind_q <= kind_q;
						slot_out_q   <= slot_q;
						bank_value_q <= rem_q[DATA_W-1:0];
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = event_kind_q;
	assign slot       = slot_out_q;
	assign bank_value = bank_value_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY) |-> (div_q != '0))
		else $error("modulo started with a zero bank count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (rem_q < div_q))
		else $error("remainder not reduced below the bank count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY) |-> (step_q != '0) && (step_q <= STEP_W'(DATA_W)))
		else $error("modulo step counter out of range");

endmodule

FILE: design/bank_switch_scanline_irq_mapper_core.sv
// Path: a result with no bank arithmetic goes from the queue straight into the output register;
// a character or program bank result first passes through the one-bit-per-cycle modulo.
// Flow: the front end takes one transaction per cycle while the queue has room; the back
// end pops nothing while a modulo runs; other results retire one per cycle unless stalled.
// Reset (arst_n low, asynchronous): command select, IRQ enable, IRQ counter, queue and output
// are cleared; the character bank count resets to 8 and the program bank count to 2.
module bank_switch_scanline_irq_mapper_core import bsim_pkg::*; #(
	parameter int QDEPTH = BSIM_QDEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port: index 0 is the character bank count, 1 the program bank count.
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CHR_CNT_W-1:0]  cfg_data,
	// Input channel.
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [ADDR_W-1:0]     bus_addr,
	input  logic [DATA_W-1:0]     bus_data,
	// Result channel.
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [KIND_W-1:0]     event_kind,
	output logic [SLOT_W-1:0]     slot,
	output logic [DATA_W-1:0]     bank_value
);

	logic [CHR_CNT_W-1:0] chr_bank_count_q;
	logic [PRG_CNT_W-1:0] prg_bank_count_q;
	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_head_valid;
	bsim_entry_t          q_entry;
	bsim_entry_t          q_head;

	// Bank counts must be written only while the block is idle (the block does not enforce it),
	// so the back end can read them live when it starts a modulo.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_bank_count_q <= CHR_CNT_W'(8);
			prg_bank_count_q <= PRG_CNT_W'(2);
		end else if (cfg_we) begin
			if (cfg_index == REG_CHR_COUNT) begin
				chr_bank_count_q <= cfg_data;
			end else begin
				prg_bank_count_q <= cfg_data[PRG_CNT_W-1:0];
			end
		end
	end

	// The front end applies every state update at accept time, so later transactions see
	// the command select and IRQ counter without waiting for the back end.
	bsim_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.bus_addr       (bus_addr),
		.bus_data       (bus_data),
		.chr_bank_count (chr_bank_count_q),
		.prg_bank_count (prg_bank_count_q),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_entry        (q_entry)
	);

	bsim_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// The back end reduces bank numbers modulo the bank count and owns the output register.
	bsim_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.chr_bank_count (chr_bank_count_q),
		.prg_bank_count (prg_bank_count_q),
		.head_valid     (q_head_valid),
		.head           (q_head),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_kind     (event_kind),
		.slot           (slot),
		.bank_value     (bank_value)
	);

endmodule

FILE: sim/bank_switch_scanline_irq_mapper_core_tb.sv
// Self-checking testbench for bank_switch_scanline_irq_mapper_core: bus writes, scanline
// ticks and bank count settings are driven in and every result is checked against a predictor.
// Depends on bsim_pkg and the core module only.
module bank_switch_scanline_irq_mapper_core_tb import bsim_pkg::*; ();

	// Command numbers that the package does not name but the stimulus needs.
	localparam logic [CSEL_W-1:0] CSEL_CHR0   = 4'd0;
	localparam logic [CSEL_W-1:0] CSEL_UNUSED = 4'd8;

	// Run length and pacing.
	localparam int CYCLE_LIMIT    = 400000;
	localparam int HOLD_CYCLES    = 80;
	localparam int END_PAD        = 20;
	localparam int PHASE_ITEMS    = 305;
	localparam int PHASES         = 6;

	// One result of the block: the kind of update, its slot and the new bank or mirroring code.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] value;
	} bank_event_t;

	// The scoreboard keeps its own copy of the mapper state and bank counts, predicts the
	// update that each accepted transaction causes and checks results in order.
	class bank_event_scoreboard;
		bank_event_t       pending[$];
		logic [CSEL_W-1:0] sel;
		bit                irq_on;
		logic [IRQ_CNT_W-1:0] irq_count;
		logic [CHR_CNT_W-1:0] chr_count;
		logic [PRG_CNT_W-1:0] prg_count;
		int                errors;

		function new();
			sel = '0;
			irq_on = 1'b0;
			irq_count = '0;
			chr_count = CHR_CNT_W'(8);
			prg_count = PRG_CNT_W'(2);
			errors = 0;
		endfunction

		function void set_count(logic idx, int count);
			if (idx == REG_CHR_COUNT)
				chr_count = CHR_CNT_W'(count);
			else
				prg_count = PRG_CNT_W'(count);
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		function void note_input(logic is_tick, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
			bank_event_t ev;
			ev.kind = EV_NONE;
			ev.slot = '0;
			ev.value = '0;
			if (is_tick == CMD_TICK) begin
				// A tick only matters while the IRQ is enabled; address and data are ignored.
				if (irq_on) begin
					if (irq_count <= TICK_DEC) begin
						irq_count = '0;
						ev.kind = EV_IRQ;
					end else begin
						irq_count = irq_count - TICK_DEC;
					end
				end
			end else if (addr == ADDR_SELECT) begin
				sel = data[CSEL_W-1:0];
			end else if (addr == ADDR_EXECUTE) begin
				if (sel <= CSEL_CHR7) begin
					if (chr_count != 0) begin
						ev.kind = EV_CHR;
						ev.slot = sel[SLOT_W-1:0];
						ev.value = DATA_W'(data % chr_count);
					end
				end else if (sel >= CSEL_PRG0 && sel <= CSEL_PRG2) begin
					if (prg_count != 0) begin
						ev.kind = EV_PRG;
						ev.slot = SLOT_W'(sel - CSEL_PRG0);
						ev.value = DATA_W'(data % prg_count);
					end
				end else if (sel == CSEL_MIRROR) begin
					ev.kind = EV_MIRROR;
					ev.value = {6'b0, data[1:0] ^ 2'b01};
				end else if (sel == CSEL_IRQEN) begin
					irq_on = (data != 0);
				end else if (sel == CSEL_CNT_LO) begin
					irq_count[7:0] = data;
				end else if (sel == CSEL_CNT_HI) begin
					irq_count[15:8] = data;
				end
			end
			pending.push_back(ev);
		endfunction

		function void check_result(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] got_slot,
				logic [DATA_W-1:0] got_value);
			bank_event_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: kind %0d slot %0d value %0d", kind, got_slot,
						got_value);
				return;
			end
			want = pending.pop_front();
			if (want.kind !== kind || want.slot !== got_slot || want.value !== got_value) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected kind %0d slot %0d value %0d, ",
						"got kind %0d slot %0d value %0d"},
						want.kind, want.slot, want.value, kind, got_slot, got_value);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = REG_CHR_COUNT;
	logic [CHR_CNT_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 cmd = CMD_WRITE;
	logic [ADDR_W-1:0]    bus_addr = '0;
	logic [DATA_W-1:0]    bus_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [KIND_W-1:0]    event_kind;
	logic [SLOT_W-1:0]    slot;
	logic [DATA_W-1:0]    bank_value;

	bank_event_scoreboard sb;

	// Control shared by the stimulus and the receiver. Idling on either side can be switched
	// off, and a long receiver hold-off can be requested from the main sequence.
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_off_req = 1'b0;
	int items_sent = 0;
	int cycles = 0;

	bank_switch_scanline_irq_mapper_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.bus_addr   (bus_addr),
		.bus_data   (bus_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_kind (event_kind),
		.slot       (slot),
		.bank_value (bank_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a run that hangs anywhere ends here as a failure.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// Receiver. Values are read right after the edge, so they are the ones the block saw.
	// A result transaction completes at an edge with out_valid high and out_stall low.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(event_kind, slot, bank_value);
	end

	// Receiver back-pressure: short random bursts, or one long hold-off on request so that
	// the queue inside the block fills and the input side stalls.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				out_stall <= 1'b0;
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one input transaction and returns at the edge where it is accepted. It is called
	// at a rising edge, and makes at most one assignment to in_valid in that time step.
	task automatic push_item(input logic is_tick, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= is_tick;
		bus_addr <= addr;
		bus_data <= data;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(is_tick, addr, data);
		items_sent++;
	endtask

	// A well-formed command: latch the command number (with random upper bits, which the
	// block must drop) and then carry it out with the given data.
	task automatic issue(input logic [CSEL_W-1:0] csel, input logic [DATA_W-1:0] data);
		push_item(CMD_WRITE, ADDR_SELECT, {4'($urandom), csel});
		push_item(CMD_WRITE, ADDR_EXECUTE, data);
	endtask

	task automatic tick();
		push_item(CMD_TICK, ADDR_W'($urandom), DATA_W'($urandom));
	endtask

	// Stops offering and waits until every predicted result has come back.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// Writes both bank counts, character count first and program count second, while the block is idle.
	task automatic write_counts(input int chr, input int prg);
		cfg_we <= 1'b1;
		cfg_index <= REG_CHR_COUNT;
		cfg_data <= CHR_CNT_W'(chr);
		@(posedge clk);
		cfg_index <= REG_PRG_COUNT;
		cfg_data <= CHR_CNT_W'(prg);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_count(REG_CHR_COUNT, chr);
		sb.set_count(REG_PRG_COUNT, prg);
	endtask

	// One random group of transactions. Most are well-formed select/execute pairs or IRQ
	// programming followed by ticks; the rest are stray addresses and broken sequences.
	task automatic random_group();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			issue(4'($urandom), 8'($urandom));
		end else if (r < 58) begin
			// Keep the counter mostly small so that a few ticks reach an IRQ request.
			issue(CSEL_CNT_LO, 8'($urandom));
			issue(CSEL_CNT_HI,
				($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)));
			issue(CSEL_IRQEN, ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
		end else if (r < 83) begin
			tick();
		end else if (r < 88) begin
			// Addresses one bit away from the two active ones.
			push_item(CMD_WRITE, (($urandom_range(0, 1) == 0) ? ADDR_SELECT : ADDR_EXECUTE)
				^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1)), 8'($urandom));
		end else if (r < 93) begin
			push_item(CMD_WRITE, ADDR_W'($urandom), 8'($urandom));
		end else begin
			// A lone execute or a lone select breaks the usual pairing.
			push_item(CMD_WRITE, ($urandom_range(0, 1) == 0) ? ADDR_SELECT : ADDR_EXECUTE,
				8'($urandom));
		end
	endtask

	initial begin
		int goal;
		int mid;
		bit hold_done;
		bit pause_done;
		sb = new();
		hold_done = 1'b0;
		pause_done = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the bank counts at their reset values (8 character, 2 program).
		// Character banks at both data extremes, the command number taken from the low nibble
		// only, the unused command, both ends of the program slots and a mirroring code.
		issue(CSEL_CHR0, 8'hFF);
		push_item(CMD_WRITE, ADDR_SELECT, {4'hF, CSEL_CHR7});
		push_item(CMD_WRITE, ADDR_EXECUTE, 8'h00);
		issue(CSEL_UNUSED, 8'h55);
		issue(CSEL_PRG0, 8'hFF);
		issue(CSEL_PRG2, 8'h80);
		issue(CSEL_MIRROR, 8'h03);
		// Counter at 226: the first tick leaves 113, the second is at the threshold and
		// requests an IRQ, the third finds zero and requests again.
		issue(CSEL_CNT_LO, 8'hE2);
		issue(CSEL_CNT_HI, 8'h00);
		issue(CSEL_IRQEN, 8'h01);
		tick();
		tick();
		push_item(CMD_TICK, ADDR_EXECUTE, 8'hFF);
		// With the IRQ disabled a tick changes nothing; then a write to an inactive address.
		issue(CSEL_IRQEN, 8'h00);
		tick();
		push_item(CMD_WRITE, 16'hFFFF, 8'hFF);

		// Random phases, each under its own pair of bank counts, extremes among them.
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: write_counts(0, 510);
				1: write_counts(2040, 2);
				2: write_counts(1, 3);
				3: write_counts($urandom_range(1, 16), $urandom_range(2, 16));
				4: write_counts(256, 255);
				default: write_counts($urandom_range(0, 2040), $urandom_range(2, 510));
			endcase
			// The last phase runs with no idling on either side.
			tx_gaps = (ph != PHASES - 1);
			rx_gaps = (ph != PHASES - 1);
			goal = items_sent + PHASE_ITEMS;
			mid = items_sent + PHASE_ITEMS / 2;
			while (items_sent < goal) begin
				random_group();
				// The receiver holds off for a long stretch while the sender keeps offering.
				if (ph == 1 && !hold_done && items_sent >= mid) begin
					hold_off_req = 1'b1;
					hold_done = 1'b1;
				end
				// The sender pauses until every result has drained, then carries on.
				if (ph == 2 && !pause_done && items_sent >= mid) begin
					settle();
					pause_done = 1'b1;
				end
			end
		end

		settle();
		// Extra edges catch any stray result that appears after the last expected one.
		repeat (END_PAD) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
design/bsim_pkg.sv
design/bsim_front.sv
design/bsim_queue.sv
design/bsim_back.sv
design/bank_switch_scanline_irq_mapper_core.sv
sim/bank_switch_scanline_irq_mapper_core_tb.sv
